/* hdl/ttu_pkg.sv */
// Package with the shared constants and codes of the tick timekeeping unit.
`default_nettype none

package ttu_pkg;

  localparam int unsigned SCALE_SHIFT = 10;

  localparam logic [31:0] TICK_LENGTH_RST   = 32'd14318;
  localparam logic [31:0] USEC_QUOTIENT_RST = 32'd299969779;
  localparam logic [19:0] NS_SCALE_RST      = 20'd1024;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_OFFSET = 2'd1,
    OP_MONO   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_TICK_LENGTH   = 2'd0,
    REG_USEC_QUOTIENT = 2'd1,
    REG_NS_SCALE      = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

/* hdl/tick_timekeeping_unit.sv */
// Top level of the tick timekeeping unit: sequencer around one shared 64-bit adder.
`default_nettype none

// One input transaction is taken at a time and yields exactly one result transaction.
// All arithmetic runs through a single 64-bit adder under a small sequencer, one bit of
// a multiplication or division per cycle. A tick mark divides out missed ticks only when
// the tick delta exceeds the tick length, then multiplies and sums; an offset query only
// multiplies, a monotonic query multiplies and sums, and an unused opcode goes straight to
// the result. The block accepts the next transaction in the cycle after the result is
// loaded, while that result may still wait for the downstream side.
module tick_timekeeping_unit
  import ttu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [95:0]         s_axis_tdata,  // timer_value[31:0], cycle_stamp[95:32]
  input  wire logic [1:0]          s_axis_tuser,  // opcode[1:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [127:0]             m_axis_tdata,  // missed_ticks[31:0], usec_offset[63:32],
                                                  // monotonic_ns[127:64]
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_DELTA = 8'b0000_0100,
    S_CYC   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [31:0]   tick_length_q;
  logic [31:0]   usec_quotient_q;
  logic [19:0]   ns_scale_q;
  logic [31:0]   last_tick_q;
  logic [63:0]   last_cycle_q;
  logic [63:0]   ns_base_q;
  logic [1:0]    op_q;
  logic [31:0]   tv_q;
  logic [63:0]   cs_q;
  logic [63:0]   acc_q;
  logic [63:0]   opa_q;
  logic [31:0]   mbits_q;
  logic [31:0]   div_q;
  logic [31:0]   rem_q;
  logic [4:0]    cnt_q;
  logic          out_valid_q;
  logic [127:0]  out_q;

  logic [63:0]   add_a;
  logic [63:0]   add_b;
  logic          add_cin;
  logic [64:0]   add_sum;
  logic          cfg_we;
  logic          can_load;
  logic          do_div;
  logic          div_bit;
  logic          cnt_last;

  assign pready        = 1'b1;
  assign cfg_we        = psel & penable & pwrite;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign can_load      = !out_valid_q || m_axis_tready;
  assign do_div        = (div_q > tick_length_q) && (last_tick_q != 32'd0);
  assign div_bit       = div_q[31];
  assign cnt_last      = (cnt_q == '1);

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_TICK_LENGTH:   prdata = tick_length_q;
      REG_USEC_QUOTIENT: prdata = usec_quotient_q;
      REG_NS_SCALE:      prdata = {12'd0, ns_scale_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_length_q   <= TICK_LENGTH_RST;
      usec_quotient_q <= USEC_QUOTIENT_RST;
      ns_scale_q      <= NS_SCALE_RST;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_TICK_LENGTH:   tick_length_q   <= pwdata;
        REG_USEC_QUOTIENT: usec_quotient_q <= pwdata;
        REG_NS_SCALE:      ns_scale_q      <= pwdata[19:0];
        default:           ;
      endcase
    end
  end

  // Operand selection for the shared adder; subtraction is addition of the complement.
  always_comb begin
    add_a   = 64'd0;
    add_b   = 64'd0;
    add_cin = 1'b0;
    case (state_q)
      S_DIFF: begin
        add_cin = 1'b1;
        case (op_q)
          OP_MARK: begin
            add_a = {32'd0, tv_q};
            add_b = {32'hFFFF_FFFF, ~tick_length_q};
          end
          OP_OFFSET: begin
            add_a = {32'd0, tv_q};
            add_b = {32'hFFFF_FFFF, ~last_tick_q};
          end
          default: begin
            add_a = cs_q;
            add_b = ~last_cycle_q;
          end
        endcase
      end
      S_DELTA: begin
        add_a   = {32'd0, tv_q};
        add_b   = {32'hFFFF_FFFF, ~last_tick_q};
        add_cin = 1'b1;
      end
      S_CYC: begin
        add_a   = cs_q;
        add_b   = ~last_cycle_q;
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_a   = {31'd0, rem_q, div_bit};
        add_b   = {32'hFFFF_FFFF, ~tick_length_q};
        add_cin = 1'b1;
      end
      S_MUL: begin
        add_a = acc_q;
        add_b = mbits_q[0] ? opa_q : 64'd0;
      end
      S_SUM: begin
        add_a = ns_base_q;
        add_b = acc_q >> SCALE_SHIFT;
      end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_cin};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_DIFF;
      S_DIFF: begin
        case (op_q)
          OP_MARK:   state_d = S_DELTA;
          OP_OFFSET: state_d = S_MUL;
          OP_MONO:   state_d = S_MUL;
          default:   state_d = S_DONE;
        endcase
      end
      S_DELTA: state_d = S_CYC;
      S_CYC:   state_d = do_div ? S_DIV : S_MUL;
      S_DIV:   if (cnt_last) state_d = S_MUL;
      S_MUL:   if (cnt_last) state_d = (op_q == OP_OFFSET) ? S_DONE : S_SUM;
      S_SUM:   state_d = S_DONE;
      S_DONE:  if (can_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      last_tick_q  <= 32'd0;
      last_cycle_q <= 64'd0;
      ns_base_q    <= 64'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && can_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_CYC) begin
        last_tick_q  <= tv_q;
        last_cycle_q <= cs_q;
      end
      if (state_q == S_SUM && op_q == OP_MARK) begin
        ns_base_q <= add_sum[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q <= s_axis_tuser;
        tv_q <= s_axis_tdata[31:0];
        cs_q <= s_axis_tdata[95:32];
      end
      S_DIFF: begin
        tv_q    <= add_sum[31:0];
        opa_q   <= (op_q == OP_OFFSET) ? {32'd0, add_sum[31:0]} : add_sum[63:0];
        acc_q   <= 64'd0;
        cnt_q   <= 5'd0;
        mbits_q <= (op_q == OP_OFFSET) ? usec_quotient_q : {12'd0, ns_scale_q};
      end
      S_DELTA: div_q <= add_sum[31:0];
      S_CYC: begin
        opa_q   <= add_sum[63:0];
        acc_q   <= 64'd0;
        cnt_q   <= 5'd0;
        mbits_q <= {12'd0, ns_scale_q};
        rem_q   <= 32'd0;
        if (!do_div) div_q <= 32'd0;
      end
      S_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        if (add_sum[64]) begin
          rem_q <= add_sum[31:0];
          div_q <= {div_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], div_bit};
          div_q <= {div_q[30:0], 1'b0};
        end
      end
      S_MUL: begin
        acc_q   <= add_sum[63:0];
        opa_q   <= {opa_q[62:0], 1'b0};
        mbits_q <= {1'b0, mbits_q[31:1]};
        cnt_q   <= cnt_q + 5'd1;
      end
      S_SUM: acc_q <= add_sum[63:0];
      S_DONE: begin
        if (can_load) begin
          out_q[31:0]   <= (op_q == OP_MARK) ? div_q : 32'd0;
          out_q[63:32]  <= (op_q == OP_OFFSET) ? acc_q[63:32] : 32'd0;
          out_q[127:64] <= (op_q == OP_MARK || op_q == OP_MONO) ? acc_q : 64'd0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ttu_checker.sv */
// Port-level checker for the tick timekeeping unit and its bind statement.
`default_nettype none

module ttu_checker
  import ttu_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [127:0]        m_axis_tdata,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pwrite,
  input wire logic [PADDR_W-1:0]  paddr,
  input wire logic [31:0]         pwdata,
  input wire logic [31:0]         prdata,
  input wire logic                pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a transaction is in progress");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready deasserted");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[3:2] == REG_TICK_LENGTH)
    |=> (paddr[3:2] != REG_TICK_LENGTH) || (prdata == $past(pwdata)))
    else $error("tick_length readback mismatch after write");

endmodule

bind tick_timekeeping_unit ttu_checker u_ttu_checker (.*);

`default_nettype wire

/* verif/tick_timekeeping_unit_tb.sv */
// Self-checking testbench for the tick timekeeping unit: directed table, then random phases.
module tick_timekeeping_unit_tb
  import ttu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         NUM_PHASES   = 8;
  localparam int         PHASE_ITEMS  = 155;

  typedef struct packed {
    logic [63:0] ns;
    logic [31:0] usec;
    logic [31:0] lost;
  } time_result_t;

  typedef struct {
    logic         is_wr;
    reg_idx_e     idx;
    logic [31:0]  wdata;
    logic [1:0]   op;
    logic [31:0]  tv;
    logic [63:0]  cs;
    logic         chk;
    time_result_t typed;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [95:0]        s_axis_tdata = '0;  // timer_value[31:0], cycle_stamp[95:32]
  logic [1:0]         s_axis_tuser = '0;  // opcode[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [127:0]       m_axis_tdata;       // missed_ticks[31:0], usec_offset[63:32],
                                          // monotonic_ns[127:64]
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  tick_timekeeping_unit dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #4 clk_i = ~clk_i;

  logic [31:0]  tick_len = TICK_LENGTH_RST;
  logic [31:0]  usec_quot = USEC_QUOTIENT_RST;
  logic [19:0]  ns_scale = NS_SCALE_RST;
  logic [31:0]  last_tick = '0;
  logic [63:0]  last_stamp = '0;
  logic [63:0]  ns_base = '0;
  logic [31:0]  track_tv = '0;
  logic [63:0]  track_cs = '0;

  time_result_t expected_times [$];
  int           err_count = 0;
  int           idle_cycles = 0;
  bit           idle_en = 1'b1;
  bit           hold_pending = 1'b0;

  stim_row_t directed_rows [0:27] = '{
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_OFFSET, 32'd0, 64'd0, 1'b1, '{64'd0, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MONO, 32'd0, 64'd0, 1'b1, '{64'd0, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MONO, 32'd0, 64'd1000, 1'b1,
      '{64'd1000, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{64'd0, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd14318, 64'd5000, 1'b1,
      '{64'd5000, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd28636, 64'd6000, 1'b1,
      '{64'd6000, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd85908, 64'd7000, 1'b1,
      '{64'd7000, 32'd0, 32'd4}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_OFFSET, 32'd71590, 64'd0, 1'b1,
      '{64'd0, 32'd0, 32'd0}},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_OFFSET, 32'hFFFF_FFFF, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MONO, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b1, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd100, 64'd10, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd100, 64'd10, 1'b0, '0},
    '{1'b1, REG_USEC_QUOTIENT, 32'hFFFF_FFFF, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_OFFSET, 32'd99, 64'd0, 1'b1,
      '{64'd0, 32'hFFFF_FFFE, 32'd0}},
    '{1'b1, REG_USEC_QUOTIENT, 32'd0, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_OFFSET, 32'd12345, 64'd0, 1'b1,
      '{64'd0, 32'd0, 32'd0}},
    '{1'b1, REG_NS_SCALE, 32'h000F_FFFF, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MONO, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{1'b1, REG_NS_SCALE, 32'd1, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MONO, 32'd0, 64'd0, 1'b0, '0},
    '{1'b1, REG_NS_SCALE, 32'hFFF0_0800, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd5, 64'd12345, 1'b0, '0},
    '{1'b1, REG_TICK_LENGTH, 32'hFFFF_FFFF, OP_MARK, 32'd0, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_MARK, 32'd3, 64'd0, 1'b0, '0},
    '{1'b0, REG_TICK_LENGTH, 32'd0, OP_OFFSET, 32'd2, 64'd0, 1'b0, '0}
  };

  function automatic logic [63:0] scaled_ns(input logic [63:0] cycles);
    logic [63:0] prod;
    prod = cycles * {44'd0, ns_scale};
    return prod >> SCALE_SHIFT;
  endfunction

  function automatic void compute_time_result(input logic [1:0] op, input logic [31:0] tv,
                                              input logic [63:0] cs, output time_result_t r);
    logic [63:0] prev_stamp;
    logic [31:0] tick_time;
    logic [31:0] delta;
    logic [63:0] prod;
    r = '0;
    if (op == OP_MARK) begin
      prev_stamp = last_stamp;
      tick_time = tv - tick_len;
      delta = tick_time - last_tick;
      last_stamp = cs;
      if (delta > tick_len && last_tick != '0) begin
        r.lost = (tick_len == '0) ? 32'hFFFF_FFFF : delta / tick_len;
      end
      last_tick = tick_time;
      ns_base = ns_base + scaled_ns(cs - prev_stamp);
      r.ns = ns_base;
    end else if (op == OP_OFFSET) begin
      delta = tv - last_tick;
      prod = {32'd0, delta} * {32'd0, usec_quot};
      r.usec = prod[63:32];
    end else if (op == OP_MONO) begin
      r.ns = ns_base + scaled_ns(cs - last_stamp);
    end
  endfunction

  function automatic void next_random_item(output logic [1:0] op, output logic [31:0] tv,
                                           output logic [63:0] cs);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op = OP_MARK;
    tv = track_tv;
    cs = track_cs;
    if (pick < 8) begin
      op = 2'($urandom_range(0, 3));
      tv = $urandom;
      cs = {$urandom, $urandom};
    end else if (pick < 45) begin
      track_tv = track_tv + tick_len * $urandom_range(1, 3) + $urandom_range(0, 7);
      track_cs = track_cs + $urandom_range(0, 1 << 20);
      tv = track_tv;
      cs = track_cs;
    end else if (pick < 75) begin
      op = OP_OFFSET;
      tv = track_tv - tick_len + $urandom_range(0, 40000);
    end else begin
      op = OP_MONO;
      cs = track_cs + $urandom_range(0, 1 << 20);
    end
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] tv, input logic [63:0] cs,
                           input logic use_typed, input time_result_t typed);
    time_result_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {cs, tv};
    do @(posedge clk_i); while (!s_axis_tready);
    compute_time_result(op, tv, cs, predicted);
    expected_times.push_back(use_typed ? typed : predicted);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TICK_LENGTH:   tick_len = value;
      REG_USEC_QUOTIENT: usec_quot = value;
      REG_NS_SCALE:      ns_scale = value[19:0];
      default: ;
    endcase
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    time_result_t got;
    time_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_times.size() == 0) begin
        $error("result transaction with no expectation pending: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_times.pop_front();
        if (got.lost !== want.lost) begin
          $error("missed_ticks mismatch: expected %0d, actual %0d", want.lost, got.lost);
          err_count++;
        end
        if (got.usec !== want.usec) begin
          $error("usec_offset mismatch: expected %0d, actual %0d", want.usec, got.usec);
          err_count++;
        end
        if (got.ns !== want.ns) begin
          $error("monotonic_ns mismatch: expected %0d, actual %0d", want.ns, got.ns);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] tv;
    logic [63:0] cs;
    logic [31:0] cfg_tick;
    logic [31:0] cfg_quot;
    logic [31:0] cfg_scale;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_wr) begin
        write_register(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].tv, directed_rows[i].cs,
                  directed_rows[i].chk, directed_rows[i].typed);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          cfg_tick = TICK_LENGTH_RST;
          cfg_quot = USEC_QUOTIENT_RST;
          cfg_scale = 32'(NS_SCALE_RST);
        end
        1: begin
          cfg_tick = 32'd1;
          cfg_quot = 32'hFFFF_FFFF;
          cfg_scale = 32'd1024000;
        end
        2: begin
          cfg_tick = 32'hFFFF_FFFF;
          cfg_quot = 32'd0;
          cfg_scale = 32'd1;
        end
        4: begin
          cfg_tick = 32'd0;
          cfg_quot = $urandom;
          cfg_scale = 32'h000F_FFFF;
        end
        5: begin
          cfg_tick = 32'd25000;
          cfg_quot = USEC_QUOTIENT_RST;
          cfg_scale = 32'd333;
        end
        6: begin
          cfg_tick = $urandom_range(1, 50);
          cfg_quot = $urandom;
          cfg_scale = $urandom_range(1, 4096);
        end
        default: begin
          cfg_tick = $urandom_range(1000, 100000);
          cfg_quot = $urandom;
          cfg_scale = $urandom_range(1, 1024000);
        end
      endcase
      write_register(REG_TICK_LENGTH, cfg_tick);
      write_register(REG_USEC_QUOTIENT, cfg_quot);
      write_register(REG_NS_SCALE, cfg_scale);
      track_tv = last_tick + tick_len;
      track_cs = last_stamp;
      idle_en = (p != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 40) begin
          hold_pending = 1'b1;
        end
        next_random_item(op, tv, cs);
        send_item(op, tv, cs, 1'b0, '0);
      end
    end

    wait_drained();
    if (err_count == 0 && expected_times.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ttu_pkg.sv
hdl/tick_timekeeping_unit.sv
hdl/ttu_checker.sv
verif/tick_timekeeping_unit_tb.sv
